[src/rounded_rect_path_generator_macros.svh]
// ----------------------------------------------------------------------------
// Rounded rectangle path generator: assertion macros
// Shared property wrappers, sampled on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ROUNDED_RECT_PATH_GENERATOR_MACROS_SVH
`define ROUNDED_RECT_PATH_GENERATOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define RRP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define RRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rrp_pkg.sv]
// ----------------------------------------------------------------------------
// Rounded rectangle path generator: package
// Shared types, constants and the elaboration-time quarter-sine series.
// ----------------------------------------------------------------------------
package rrp_pkg;

  localparam int unsigned COORD_W           = 16;
  localparam int unsigned RADIUS_W          = 15;
  localparam int unsigned KEEP_W            = 4;
  localparam int unsigned SEG_W             = 4;
  localparam int unsigned MIN_SEGMENTS      = 3;
  localparam int unsigned MAX_SEGMENTS_DEF  = 15;
  localparam int unsigned SINE_BITS_DEF     = 16;
  localparam logic [SEG_W-1:0] ARC_SEGMENTS_RESET = 4'd15;

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SETUP = 2'd1,
    ST_RUN   = 2'd2
  } state_e;

  // one vertex request from the sequencer
  typedef struct packed {
    logic             valid;
    corner_e          corner;
    logic             sharp;
    logic             last;
    logic [SEG_W-1:0] k;
    logic [SEG_W-1:0] segs;
  } rrp_token_t;

  // geometry of the rectangle in flight, radius already clamped
  typedef struct packed {
    logic [COORD_W-1:0]  left_x;
    logic [COORD_W-1:0]  top_y;
    logic [COORD_W-1:0]  right_x;
    logic [COORD_W-1:0]  bottom_y;
    logic [RADIUS_W-1:0] radius;
  } rrp_item_t;

  // divide by the segment count, one fixed divisor per arm
  function automatic logic [63:0] seg_div(input logic [63:0] num, input int unsigned s);
    logic [63:0] res;
    case (s)
      3:       res = num / 64'd3;
      4:       res = num / 64'd4;
      5:       res = num / 64'd5;
      6:       res = num / 64'd6;
      7:       res = num / 64'd7;
      8:       res = num / 64'd8;
      9:       res = num / 64'd9;
      10:      res = num / 64'd10;
      11:      res = num / 64'd11;
      12:      res = num / 64'd12;
      13:      res = num / 64'd13;
      14:      res = num / 64'd14;
      15:      res = num / 64'd15;
      default: res = num;
    endcase
    return res;
  endfunction

  // sin(pi/2 * k/s), Taylor series in Q2.30, rounded to frac bits, capped at 1.0
  function automatic logic [63:0] quarter_sine(input int unsigned k, input int unsigned s,
                                               input int unsigned frac);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] q;
    x    = seg_div(HALF_PI_Q30 * 64'(k) + 64'(s >> 1), s);
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = '0;
    term = ((term * x2) >> 30) / 64'd6;   neg = neg + term;
    term = ((term * x2) >> 30) / 64'd20;  pos = pos + term;
    term = ((term * x2) >> 30) / 64'd42;  neg = neg + term;
    term = ((term * x2) >> 30) / 64'd72;  pos = pos + term;
    term = ((term * x2) >> 30) / 64'd110; neg = neg + term;
    term = ((term * x2) >> 30) / 64'd156; pos = pos + term;
    term = ((term * x2) >> 30) / 64'd210; neg = neg + term;
    term = ((term * x2) >> 30) / 64'd272; pos = pos + term;
    term = ((term * x2) >> 30) / 64'd342; neg = neg + term;
    term = ((term * x2) >> 30) / 64'd420; pos = pos + term;
    q = (pos > neg) ? pos - neg : 64'd0;
    q = (q + (64'd1 << (29 - frac))) >> (30 - frac);
    if (q > (64'd1 << frac)) begin
      q = 64'd1 << frac;
    end
    return q;
  endfunction

endpackage

[src/rrp_arc_datapath.sv]
// ----------------------------------------------------------------------------
// Rounded rectangle path generator: vertex datapath
// Three register stages: sine lookup and base point, radius multiply,
// rounding and corner-dependent offset.
// ----------------------------------------------------------------------------
module rrp_arc_datapath #(
  parameter int unsigned MAX_SEGMENTS = rrp_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned SINE_BITS    = rrp_pkg::SINE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rrp_pkg::rrp_token_t          token_i,
  input  rrp_pkg::rrp_item_t           item_i,
  output logic                         point_valid_o,
  output logic [rrp_pkg::COORD_W-1:0]  point_x_o,
  output logic [rrp_pkg::COORD_W-1:0]  point_y_o,
  output logic                         last_point_o
);
  import rrp_pkg::*;

  localparam int unsigned FRAC_BITS = SINE_BITS - 1;
  localparam int unsigned PROD_W    = RADIUS_W + SINE_BITS;
  localparam int unsigned LUT_DEPTH = 2 ** (2 * SEG_W);
  localparam int unsigned LUT_W     = LUT_DEPTH * SINE_BITS;
  localparam logic [PROD_W:0] ROUND_HALF = {{PROD_W{1'b0}}, 1'b1} << (FRAC_BITS - 1);

  // entry {s, k} holds the rounded sine of k/s of a quarter turn
  function automatic logic [LUT_W-1:0] build_lut();
    logic [LUT_W-1:0] lut;
    lut = '0;
    for (int s = MIN_SEGMENTS; s <= MAX_SEGMENTS; s++) begin
      for (int k = 0; k <= s; k++) begin
        lut[(s * (2 ** SEG_W) + k) * SINE_BITS +: SINE_BITS] =
          SINE_BITS'(quarter_sine(k, s, FRAC_BITS));
      end
    end
    return lut;
  endfunction

  localparam logic [LUT_W-1:0] SINE_LUT = build_lut();

  // stage 1
  logic [2*SEG_W-1:0]   sin_idx;
  logic [2*SEG_W-1:0]   cos_idx;
  logic [SEG_W-1:0]     cos_k;
  logic                 is_left;
  logic                 is_top;
  logic [COORD_W-1:0]   offset;
  logic [COORD_W-1:0]   src_x;
  logic [COORD_W-1:0]   src_y;
  logic                 s1_valid_q;
  corner_e              s1_corner_q;
  logic                 s1_sharp_q;
  logic                 s1_last_q;
  logic [SINE_BITS-1:0] s1_sin_q;
  logic [SINE_BITS-1:0] s1_cos_q;
  logic [COORD_W-1:0]   s1_base_x_q;
  logic [COORD_W-1:0]   s1_base_y_q;
  logic [RADIUS_W-1:0]  s1_radius_q;

  assign cos_k   = token_i.segs - token_i.k;
  assign sin_idx = {token_i.segs, token_i.k};
  assign cos_idx = {token_i.segs, cos_k};
  assign is_left = (token_i.corner == CORNER_TL) || (token_i.corner == CORNER_BL);
  assign is_top  = (token_i.corner == CORNER_TL) || (token_i.corner == CORNER_TR);
  assign offset  = token_i.sharp ? '0 : {1'b0, item_i.radius};
  assign src_x   = is_left ? item_i.left_x + offset : item_i.right_x - offset;
  assign src_y   = is_top ? item_i.top_y + offset : item_i.bottom_y - offset;

  // stage 2
  logic                s2_valid_q;
  corner_e             s2_corner_q;
  logic                s2_sharp_q;
  logic                s2_last_q;
  logic [PROD_W-1:0]   s2_prod_s_q;
  logic [PROD_W-1:0]   s2_prod_c_q;
  logic [COORD_W-1:0]  s2_base_x_q;
  logic [COORD_W-1:0]  s2_base_y_q;

  // stage 3
  logic [PROD_W:0]     round_s;
  logic [PROD_W:0]     round_c;
  logic [PROD_W:0]     shift_s;
  logic [PROD_W:0]     shift_c;
  logic [COORD_W-1:0]  dsin;
  logic [COORD_W-1:0]  dcos;
  logic [COORD_W-1:0]  point_x_d;
  logic [COORD_W-1:0]  point_y_d;
  logic                valid_q;
  logic [COORD_W-1:0]  point_x_q;
  logic [COORD_W-1:0]  point_y_q;
  logic                last_q;

  assign round_s = {1'b0, s2_prod_s_q} + ROUND_HALF;
  assign round_c = {1'b0, s2_prod_c_q} + ROUND_HALF;
  assign shift_s = round_s >> FRAC_BITS;
  assign shift_c = round_c >> FRAC_BITS;
  assign dsin    = shift_s[COORD_W-1:0];
  assign dcos    = shift_c[COORD_W-1:0];

  always_comb begin
    point_x_d = s2_base_x_q;
    point_y_d = s2_base_y_q;
    if (!s2_sharp_q) begin
      case (s2_corner_q)
        CORNER_TL: begin
          point_x_d = s2_base_x_q - dcos;
          point_y_d = s2_base_y_q - dsin;
        end
        CORNER_TR: begin
          point_x_d = s2_base_x_q + dsin;
          point_y_d = s2_base_y_q - dcos;
        end
        CORNER_BR: begin
          point_x_d = s2_base_x_q + dcos;
          point_y_d = s2_base_y_q + dsin;
        end
        default: begin
          point_x_d = s2_base_x_q - dsin;
          point_y_d = s2_base_y_q + dcos;
        end
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      s1_valid_q <= token_i.valid;
      s2_valid_q <= s1_valid_q;
      valid_q    <= s2_valid_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    s1_corner_q <= token_i.corner;
    s1_sharp_q  <= token_i.sharp;
    s1_last_q   <= token_i.last;
    s1_sin_q    <= SINE_LUT[sin_idx * SINE_BITS +: SINE_BITS];
    s1_cos_q    <= SINE_LUT[cos_idx * SINE_BITS +: SINE_BITS];
    s1_base_x_q <= src_x;
    s1_base_y_q <= src_y;
    s1_radius_q <= item_i.radius;

    s2_corner_q <= s1_corner_q;
    s2_sharp_q  <= s1_sharp_q;
    s2_last_q   <= s1_last_q;
    s2_prod_s_q <= PROD_W'(s1_radius_q) * PROD_W'(s1_sin_q);
    s2_prod_c_q <= PROD_W'(s1_radius_q) * PROD_W'(s1_cos_q);
    s2_base_x_q <= s1_base_x_q;
    s2_base_y_q <= s1_base_y_q;

    point_x_q   <= point_x_d;
    point_y_q   <= point_y_d;
    last_q      <= s2_last_q && s2_valid_q;
  end

  assign point_valid_o = valid_q;
  assign point_x_o     = point_x_q;
  assign point_y_o     = point_y_q;
  assign last_point_o  = last_q;

endmodule

[src/rounded_rect_path_generator.sv]
// ----------------------------------------------------------------------------
// Rounded rectangle path generator: top level
// Turns one rectangle request into its clockwise rounded outline vertices.
// ----------------------------------------------------------------------------
// A request (start high while busy is low) carries a box, a corner radius and
// four keep-sharp flags. The block answers with the outline vertices, one per
// cycle on point_x_o/point_y_o marked by point_valid_o, corners in the order
// top-left, top-right, bottom-right, bottom-left, last_point_o set on the
// final one. A sharp corner gives one vertex, a rounded one s+1 vertices,
// where s is arc_segments held in [3, MAX_SEGMENTS]; N runs from 4 to
// 4*(MAX_SEGMENTS+1) vertices. The sequencer passes a setup state and then
// issues one vertex per cycle; busy stays high from the taken request until
// the last vertex is issued, and a new request is taken once busy is low.
// Vertices leave a three-stage pipeline (sine table, radius multiply, round
// and offset) behind a token register, so the tail of one outline may still
// be draining while the next request is set up. Results cannot be held off:
// the receiver must take every strobed vertex. Write arc_segments only while
// no outline is in flight.
module rounded_rect_path_generator #(
  parameter int unsigned MAX_SEGMENTS = rrp_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned SINE_BITS    = rrp_pkg::SINE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [rrp_pkg::SEG_W-1:0]           cfg_wdata_i,
  // request
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rrp_pkg::COORD_W-1:0]  left_x_i,
  input  logic signed [rrp_pkg::COORD_W-1:0]  top_y_i,
  input  logic signed [rrp_pkg::COORD_W-1:0]  right_x_i,
  input  logic signed [rrp_pkg::COORD_W-1:0]  bottom_y_i,
  input  logic [rrp_pkg::RADIUS_W-1:0]        corner_radius_i,
  input  logic [rrp_pkg::KEEP_W-1:0]          keep_corners_i,
  // vertices
  output logic                                point_valid_o,
  output logic signed [rrp_pkg::COORD_W-1:0]  point_x_o,
  output logic signed [rrp_pkg::COORD_W-1:0]  point_y_o,
  output logic                                last_point_o
);
  import rrp_pkg::*;

  logic                 accept;
  state_e               state_q;
  state_e               state_d;
  logic [SEG_W-1:0]     arc_segments_q;
  logic [SEG_W-1:0]     segs_clamped;
  logic [SEG_W-1:0]     segs_q;

  // request held for the whole outline
  logic [COORD_W-1:0]   left_x_q;
  logic [COORD_W-1:0]   top_y_q;
  logic [COORD_W-1:0]   right_x_q;
  logic [COORD_W-1:0]   bottom_y_q;
  logic [RADIUS_W-1:0]  req_radius_q;
  logic [KEEP_W-1:0]    keep_q;

  // radius clamp
  logic [COORD_W:0]     width_x;
  logic [COORD_W:0]     height_y;
  logic                 box_empty;
  logic [RADIUS_W-1:0]  half_w;
  logic [RADIUS_W-1:0]  half_h;
  logic [RADIUS_W-1:0]  min_half;
  logic [RADIUS_W-1:0]  radius_d;
  logic [RADIUS_W-1:0]  radius_q;

  // vertex sequencer
  corner_e              corner_q;
  corner_e              corner_d;
  logic [SEG_W-1:0]     k_q;
  logic [SEG_W-1:0]     k_d;
  logic                 sharp_now;
  logic                 corner_done;
  rrp_token_t           token_q;
  rrp_token_t           token_d;
  rrp_item_t            item;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // segment count held in its legal range
  always_comb begin
    segs_clamped = arc_segments_q;
    if (arc_segments_q < SEG_W'(MIN_SEGMENTS)) begin
      segs_clamped = SEG_W'(MIN_SEGMENTS);
    end else if (arc_segments_q > SEG_W'(MAX_SEGMENTS)) begin
      segs_clamped = SEG_W'(MAX_SEGMENTS);
    end
  end

  // effective radius: min(request, w/2, h/2), zero for an empty or inverted box
  assign width_x   = {right_x_q[COORD_W-1], right_x_q} - {left_x_q[COORD_W-1], left_x_q};
  assign height_y  = {bottom_y_q[COORD_W-1], bottom_y_q} - {top_y_q[COORD_W-1], top_y_q};
  assign box_empty = width_x[COORD_W] || (width_x == '0) ||
                     height_y[COORD_W] || (height_y == '0);
  assign half_w    = width_x[COORD_W-1:1];
  assign half_h    = height_y[COORD_W-1:1];
  assign min_half  = (half_w < half_h) ? half_w : half_h;
  assign radius_d  = box_empty ? '0 :
                     ((min_half < req_radius_q) ? min_half : req_radius_q);

  assign sharp_now   = (radius_q == '0) || keep_q[corner_q];
  assign corner_done = sharp_now || (k_q == segs_q);

  always_comb begin
    state_d  = state_q;
    corner_d = corner_q;
    k_d      = k_q;
    token_d  = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d  = ST_RUN;
        corner_d = CORNER_TL;
        k_d      = '0;
      end
      ST_RUN: begin
        token_d.valid  = 1'b1;
        token_d.corner = corner_q;
        token_d.sharp  = sharp_now;
        token_d.last   = (corner_q == CORNER_BL) && corner_done;
        token_d.k      = k_q;
        token_d.segs   = segs_q;
        if (corner_done) begin
          k_d      = '0;
          corner_d = corner_e'(corner_q + 2'd1);
          if (corner_q == CORNER_BL) begin
            state_d = ST_IDLE;
          end
        end else begin
          k_d = k_q + SEG_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      corner_q       <= CORNER_TL;
      k_q            <= '0;
      token_q        <= '0;
      arc_segments_q <= ARC_SEGMENTS_RESET;
    end else begin
      state_q  <= state_d;
      corner_q <= corner_d;
      k_q      <= k_d;
      token_q  <= token_d;
      if (cfg_we_i) begin
        arc_segments_q <= cfg_wdata_i;
      end
    end
  end

  // request capture; the datapath has taken the previous tail by then
  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_x_q     <= left_x_i;
      top_y_q      <= top_y_i;
      right_x_q    <= right_x_i;
      bottom_y_q   <= bottom_y_i;
      req_radius_q <= corner_radius_i;
      keep_q       <= keep_corners_i;
      segs_q       <= segs_clamped;
    end
    if (state_q == ST_SETUP) begin
      radius_q <= radius_d;
    end
  end

  assign item = '{left_x:   left_x_q,
                  top_y:    top_y_q,
                  right_x:  right_x_q,
                  bottom_y: bottom_y_q,
                  radius:   radius_q};

  rrp_arc_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SINE_BITS    (SINE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .token_i       (token_q),
    .item_i        (item),
    .point_valid_o (point_valid_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .last_point_o  (last_point_o)
  );

endmodule

[src/rrp_checker.sv]
// ----------------------------------------------------------------------------
// Rounded rectangle path generator: port checker
// Timing relations between request handshake and vertex strobe.
// ----------------------------------------------------------------------------
`include "rounded_rect_path_generator_macros.svh"

module rrp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic point_valid_o,
  input logic last_point_o
);

  `RRP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request taken but busy stayed low")
  `RRP_ASSERT_NEXT(a_busy_hold, $rose(busy), busy, "busy held for a single cycle only")
  `RRP_ASSERT_SAME(a_tail_delay, $fell(busy), ##3 (point_valid_o && last_point_o), "final vertex not three cycles after busy fell")
  `RRP_ASSERT_NEXT(a_gap_after_last, point_valid_o && last_point_o, !point_valid_o, "vertex right after final vertex")

endmodule

bind rounded_rect_path_generator rrp_checker u_rrp_checker (.*);
